// ----- src/mhse_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhse_pkg
// Shared widths, reset values and register indexes of the MinHash engine.
// ----------------------------------------------------------------------------
package mhse_pkg;

	localparam int unsigned NUM_SLOTS_DEF = 16;
	localparam int unsigned MAX_SLOTS     = 64;

	localparam int unsigned VAL_W   = 31;
	localparam int unsigned SLOT_W  = 6;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned PROD_W  = 2 * VAL_W;
	localparam int unsigned DVD_W   = 64;

	// remainder unit retires this many dividend bits per cycle
	localparam int unsigned MOD_BITS_PER_CYCLE = 2;
	localparam int unsigned MOD_STEPS          = DVD_W / MOD_BITS_PER_CYCLE;
	localparam int unsigned MOD_STEP_W         = $clog2(MOD_STEPS);

	localparam logic [VAL_W-1:0]   MODULUS_RESET    = 31'h7FFF_FFFF;
	localparam logic [COUNT_W-1:0] HASH_COUNT_RESET = 7'd16;

	localparam int unsigned REG_IDX_W = 1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MODULUS    = 1'b0,
		REG_HASH_COUNT = 1'b1
	} reg_idx_t;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_HASH = 1'b1
	} action_t;

endpackage

// ----- src/mhse_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhse_if
// Valid/ready channels of the MinHash engine: input items and signature words.
// ----------------------------------------------------------------------------
interface mhse_in_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [mhse_pkg::SLOT_W-1:0] slot_index;
	logic [mhse_pkg::VAL_W-1:0]  coef_mul;
	logic [mhse_pkg::VAL_W-1:0]  coef_add;
	logic [mhse_pkg::VAL_W-1:0]  element_id;
	logic                        set_last;

	modport source (
		output valid, action, slot_index, coef_mul, coef_add, element_id, set_last,
		input  ready
	);
	modport sink (
		input  valid, action, slot_index, coef_mul, coef_add, element_id, set_last,
		output ready
	);
endinterface

interface mhse_out_if;
	logic                        valid;
	logic                        ready;
	logic [mhse_pkg::SLOT_W-1:0] out_slot;
	logic [mhse_pkg::VAL_W-1:0]  min_value;
	logic                        run_last;

	modport source (
		output valid, out_slot, min_value, run_last,
		input  ready
	);
	modport sink (
		input  valid, out_slot, min_value, run_last,
		output ready
	);
endinterface

// ----- src/mhse_mod_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhse_mod_unit
// Shared hash unit: (a * id + b) mod m, one multiply, one add, then a
// restoring remainder over the 64-bit dividend, two bits a cycle.
// ----------------------------------------------------------------------------
module mhse_mod_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mhse_pkg::VAL_W-1:0] coef_mul,
	input  logic [mhse_pkg::VAL_W-1:0] coef_add,
	input  logic [mhse_pkg::VAL_W-1:0] element_id,
	input  logic [mhse_pkg::VAL_W-1:0] modulus,
	output logic                       done,
	output logic [mhse_pkg::VAL_W-1:0] hash
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ADD,
		PH_DIV
	} phase_t;

	phase_t                          phase_q;
	logic [mhse_pkg::PROD_W-1:0]     prod_q;
	logic [mhse_pkg::DVD_W-1:0]      dvd_q;
	logic [mhse_pkg::VAL_W-1:0]      rem_q;
	logic [mhse_pkg::MOD_STEP_W-1:0] step_q;
	logic                            done_q;
	logic [mhse_pkg::VAL_W-1:0]      hash_q;

	logic [mhse_pkg::VAL_W:0]   m_ext;
	logic [mhse_pkg::VAL_W:0]   t1;
	logic [mhse_pkg::VAL_W:0]   t2;
	logic [mhse_pkg::VAL_W-1:0] r1;
	logic [mhse_pkg::VAL_W-1:0] rem_nx;

	always_comb begin
		m_ext = {1'b0, modulus};
		t1 = {rem_q, dvd_q[mhse_pkg::DVD_W-1]};
		if (t1 >= m_ext) begin
			t1 = t1 - m_ext;
		end
		r1 = t1[mhse_pkg::VAL_W-1:0];
		t2 = {r1, dvd_q[mhse_pkg::DVD_W-2]};
		if (t2 >= m_ext) begin
			t2 = t2 - m_ext;
		end
		rem_nx = t2[mhse_pkg::VAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						prod_q  <= mhse_pkg::PROD_W'(coef_mul) * mhse_pkg::PROD_W'(element_id);
						phase_q <= PH_ADD;
					end
				end
				PH_ADD: begin
					dvd_q   <= mhse_pkg::DVD_W'(prod_q) + mhse_pkg::DVD_W'(coef_add);
					rem_q   <= '0;
					step_q  <= '0;
					phase_q <= PH_DIV;
				end
				PH_DIV: begin
					rem_q  <= rem_nx;
					dvd_q  <= dvd_q << mhse_pkg::MOD_BITS_PER_CYCLE;
					step_q <= step_q + mhse_pkg::MOD_STEP_W'(1);
					if (step_q == mhse_pkg::MOD_STEP_W'(mhse_pkg::MOD_STEPS - 1)) begin
						hash_q  <= (modulus == '0) ? '0 : rem_nx;
						done_q  <= 1'b1;
						phase_q <= PH_IDLE;
					end
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign hash = hash_q;

endmodule

// ----- src/minhash_signature_engine_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minhash_signature_engine_top
// MinHash signature engine: per-slot universal hash and running minimum.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready input. action load writes a slot's (a, b); action hash
//            folds element_id into every slot in use; set_last closes the set.
//   result : valid/ready output, one signature word per slot in use, in slot
//            order, run_last on the final one, sent only after a last element.
//   wr_en/wr_index/wr_data : register writes (modulus, hash_count), idle only.
// Timing:
//   A load transaction completes in its accept cycle; ready stays high.
//   A hash transaction runs, per slot in use, a fetch, one multiply, one
//   64-bit add, the remainder steps on the shared unit and one compare/update
//   step. ready is low throughout.
//   Each signature word is read out in ST_EMIT_RD and then held in the output
//   register until the receiver takes it; nothing new is taken until the
//   whole signature has been handed over.
// Reset:
//   Registers return to their defaults and every minimum reads as the reset
//   modulus. Coefficients are undefined until loaded.
// ----------------------------------------------------------------------------
module minhash_signature_engine_top #(
	parameter int unsigned NUM_SLOTS = mhse_pkg::NUM_SLOTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	mhse_in_if.sink                              item,
	mhse_out_if.source                           result,
	input  logic                                 wr_en,
	input  logic [mhse_pkg::REG_IDX_W-1:0]       wr_index,
	input  logic [mhse_pkg::VAL_W-1:0]           wr_data
);

	localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int unsigned CNT_W = $clog2(NUM_SLOTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_HASH,
		ST_WAIT,
		ST_EMIT_RD,
		ST_EMIT_WAIT
	} state_t;

	state_t                         state_q;
	logic [mhse_pkg::VAL_W-1:0]     modulus_q;
	logic [mhse_pkg::COUNT_W-1:0]   hash_count_q;
	logic [mhse_pkg::VAL_W-1:0]     min_init_q;
	logic [NUM_SLOTS-1:0]           min_vld_q;
	logic [CNT_W-1:0]               slot_q;
	logic [CNT_W-1:0]               used_q;
	logic [mhse_pkg::VAL_W-1:0]     id_q;
	logic                           last_q;
	logic [mhse_pkg::VAL_W-1:0]     coef_a_q;
	logic [mhse_pkg::VAL_W-1:0]     coef_b_q;
	logic [mhse_pkg::VAL_W-1:0]     cur_min_q;
	logic                           out_valid_q;
	logic [mhse_pkg::SLOT_W-1:0]    out_slot_q;
	logic [mhse_pkg::VAL_W-1:0]     out_min_q;
	logic                           out_last_q;

	logic [mhse_pkg::VAL_W-1:0] mul_mem [NUM_SLOTS];
	logic [mhse_pkg::VAL_W-1:0] add_mem [NUM_SLOTS];
	logic [mhse_pkg::VAL_W-1:0] min_mem [NUM_SLOTS];

	logic                       in_acc;
	logic                       load_wr;
	logic                       min_wr;
	logic [IDX_W-1:0]           idx;
	logic [CNT_W-1:0]           slot_nx;
	logic [CNT_W-1:0]           used_nx;
	logic                       hash_done;
	logic [mhse_pkg::VAL_W-1:0] hash_val;

	assign in_acc  = item.valid && (state_q == ST_IDLE);
	assign load_wr = in_acc && (item.action == mhse_pkg::ACT_LOAD)
		&& (7'(item.slot_index) < 7'(NUM_SLOTS));
	assign min_wr  = (state_q == ST_WAIT) && hash_done && (hash_val < cur_min_q);
	assign idx     = slot_q[IDX_W-1:0];
	assign slot_nx = slot_q + CNT_W'(1);
	assign used_nx = (hash_count_q > mhse_pkg::COUNT_W'(NUM_SLOTS))
		? CNT_W'(NUM_SLOTS) : CNT_W'(hash_count_q);

	mhse_mod_unit u_mod (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (state_q == ST_HASH),
		.coef_mul   (coef_a_q),
		.coef_add   (coef_b_q),
		.element_id (id_q),
		.modulus    (modulus_q),
		.done       (hash_done),
		.hash       (hash_val)
	);

	always_ff @(posedge clk) begin
		if (load_wr) begin
			mul_mem[item.slot_index[IDX_W-1:0]] <= item.coef_mul;
			add_mem[item.slot_index[IDX_W-1:0]] <= item.coef_add;
		end
		if (min_wr) begin
			min_mem[idx] <= hash_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q    <= mhse_pkg::MODULUS_RESET;
			hash_count_q <= mhse_pkg::HASH_COUNT_RESET;
		end else if (wr_en) begin
			unique case (mhse_pkg::reg_idx_t'(wr_index))
				mhse_pkg::REG_MODULUS:    modulus_q    <= wr_data;
				mhse_pkg::REG_HASH_COUNT: hash_count_q <= wr_data[mhse_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			min_init_q  <= mhse_pkg::MODULUS_RESET;
			min_vld_q   <= '0;
			slot_q      <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (item.action == mhse_pkg::ACT_HASH)) begin
						id_q   <= item.element_id;
						last_q <= item.set_last;
						used_q <= used_nx;
						slot_q <= '0;
						if (used_nx != '0) begin
							state_q <= ST_FETCH;
						end else if (item.set_last) begin
							min_vld_q  <= '0;
							min_init_q <= modulus_q;
						end
					end
				end
				ST_FETCH: begin
					coef_a_q  <= mul_mem[idx];
					coef_b_q  <= add_mem[idx];
					cur_min_q <= min_vld_q[idx] ? min_mem[idx] : min_init_q;
					state_q   <= ST_HASH;
				end
				ST_HASH: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (hash_done) begin
						if (min_wr) begin
							min_vld_q[idx] <= 1'b1;
						end
						if (slot_nx == used_q) begin
							slot_q  <= '0;
							state_q <= last_q ? ST_EMIT_RD : ST_IDLE;
						end else begin
							slot_q  <= slot_nx;
							state_q <= ST_FETCH;
						end
					end
				end
				ST_EMIT_RD: begin
					out_slot_q  <= mhse_pkg::SLOT_W'(slot_q);
					out_min_q   <= min_vld_q[idx] ? min_mem[idx] : min_init_q;
					out_last_q  <= (slot_nx == used_q);
					out_valid_q <= 1'b1;
					state_q     <= ST_EMIT_WAIT;
				end
				ST_EMIT_WAIT: begin
					if (result.ready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							min_vld_q  <= '0;
							min_init_q <= modulus_q;
							slot_q     <= '0;
							state_q    <= ST_IDLE;
						end else begin
							slot_q  <= slot_nx;
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item.ready       = (state_q == ST_IDLE);
	assign result.valid     = out_valid_q;
	assign result.out_slot  = out_slot_q;
	assign result.min_value = out_min_q;
	assign result.run_last  = out_last_q;

endmodule

// ----- sim/mhse_sig_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhse_sig_checker
// Watches the item and signature channels and the register port of the
// MinHash engine, keeps its own copy of coefficients, minima and registers,
// predicts every signature word and compares it field by field on handover.
// ----------------------------------------------------------------------------
module mhse_sig_checker
	import mhse_pkg::*;
#(
	parameter int unsigned SLOTS = NUM_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	mhse_in_if                   items_in,
	mhse_out_if                  sig_out,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [VAL_W-1:0]     wr_data,
	input  logic                 end_of_run,
	output int                   open_words,
	output int                   words_checked,
	output int                   fail_count
);

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [VAL_W-1:0]  min_value;
		logic              run_last;
	} sig_word_t;

	logic [VAL_W-1:0]   modulus_reg;
	logic [COUNT_W-1:0] hash_count_reg;
	logic [VAL_W-1:0]   mul_tbl [SLOTS];
	logic [VAL_W-1:0]   add_tbl [SLOTS];
	logic [VAL_W-1:0]   min_tbl [SLOTS];
	sig_word_t          words_due [$];
	int                 errors = 0;
	int                 checked = 0;
	bit                 closed = 1'b0;

	function automatic logic [VAL_W-1:0] univ_hash(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
			input logic [VAL_W-1:0] id, input logic [VAL_W-1:0] m);
		logic [63:0] acc;
		if (m == '0)
			return '0;
		acc = 64'(a) * 64'(id) + 64'(b);
		return VAL_W'(acc % 64'(m));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sig_word_t   got;
		sig_word_t   want;
		int unsigned used;
		logic [VAL_W-1:0] h;
		if (!arst_n) begin
			modulus_reg    = MODULUS_RESET;
			hash_count_reg = HASH_COUNT_RESET;
			for (int s = 0; s < SLOTS; s++) begin
				mul_tbl[s] = '0;
				add_tbl[s] = '0;
				min_tbl[s] = MODULUS_RESET;
			end
			words_due.delete();
		end else begin
			if (sig_out.valid && sig_out.ready) begin
				got = '{slot: sig_out.out_slot, min_value: sig_out.min_value,
					run_last: sig_out.run_last};
				if (words_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected signature word: slot %0d min %0d last %0b",
							got.slot, got.min_value, got.run_last);
				end else begin
					want = words_due.pop_front();
					checked++;
					if (got.slot !== want.slot || got.min_value !== want.min_value ||
							got.run_last !== want.run_last) begin
						errors++;
						if (errors <= 10)
							$display({"signature word mismatch: expected slot %0d min %0d last %0b,",
								" got slot %0d min %0d last %0b"},
								want.slot, want.min_value, want.run_last,
								got.slot, got.min_value, got.run_last);
					end
				end
			end

			if (wr_en) begin
				case (reg_idx_t'(wr_index))
					REG_MODULUS: begin
						modulus_reg = wr_data;
					end
					REG_HASH_COUNT: begin
						hash_count_reg = wr_data[COUNT_W-1:0];
					end
					default: begin
					end
				endcase
			end

			if (items_in.valid && items_in.ready) begin
				if (items_in.action == ACT_LOAD) begin
					// loads past the built slots are dropped
					if (items_in.slot_index < SLOTS) begin
						mul_tbl[items_in.slot_index] = items_in.coef_mul;
						add_tbl[items_in.slot_index] = items_in.coef_add;
					end
				end else begin
					used = (hash_count_reg > SLOTS) ? SLOTS : hash_count_reg;
					for (int s = 0; s < used; s++) begin
						h = univ_hash(mul_tbl[s], add_tbl[s], items_in.element_id, modulus_reg);
						if (h < min_tbl[s])
							min_tbl[s] = h;
					end
					if (items_in.set_last) begin
						for (int s = 0; s < used; s++)
							words_due.push_back('{slot: SLOT_W'(s), min_value: min_tbl[s],
								run_last: (s + 1 == used)});
						for (int s = 0; s < SLOTS; s++)
							min_tbl[s] = modulus_reg;
					end
				end
			end

			if (end_of_run && !closed) begin
				closed = 1'b1;
				if (words_due.size() != 0) begin
					errors += words_due.size();
					$display("%0d signature words never arrived", words_due.size());
				end
			end
		end
		open_words    <= words_due.size();
		words_checked <= checked;
		fail_count    <= errors;
	end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the MinHash signature engine: coefficient loads,
// directed corner sets, then random sets over several register settings
// with random idling on both channels, one long receiver hold-off and one
// full drain mid-phase. Checking lives in mhse_sig_checker.
// ----------------------------------------------------------------------------
module tb_top;
	import mhse_pkg::*;

	localparam int unsigned HASH_LAT      = 1 + 36 * NUM_SLOTS_DEF;
	localparam int unsigned SETTLE_CYCLES = HASH_LAT + 16;
	localparam int unsigned HOLD_CYCLES   = 3000;
	localparam int unsigned CYCLE_LIMIT   = 1_000_000;
	localparam logic [VAL_W-1:0] VAL_MAX  = '1;

	typedef struct {
		action_t           action;
		logic [SLOT_W-1:0] slot;
		logic [VAL_W-1:0]  mul;
		logic [VAL_W-1:0]  add;
		logic [VAL_W-1:0]  id;
		logic              last;
	} elem_item_t;

	typedef struct {
		logic [VAL_W-1:0]   modulus;
		logic [COUNT_W-1:0] hash_count;
		int                 send_idle;
		int                 recv_idle;
		int                 n_items;
		bit                 hold;
		bit                 pause;
	} phase_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [VAL_W-1:0]     wr_data;
	logic                 end_of_run;
	logic                 hold_arm;
	logic                 hold_off;
	int                   send_idle;
	int                   recv_idle;
	int                   cycles = 0;
	int                   items_sent = 0;
	int                   open_words;
	int                   words_checked;
	int                   fail_count;
	phase_t               phases [7];

	mhse_in_if  items_in ();
	mhse_out_if sig_out ();

	minhash_signature_engine_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (items_in.sink),
		.result   (sig_out.source),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	mhse_sig_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.items_in      (items_in),
		.sig_out       (sig_out),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.end_of_run    (end_of_run),
		.open_words    (open_words),
		.words_checked (words_checked),
		.fail_count    (fail_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("cycle limit of %0d reached", CYCLE_LIMIT);
			$display("tb_top failed");
			$finish;
		end
	end

	always @(posedge clk)
		sig_out.ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle);

	// one long receiver stall once signature words start flowing
	initial begin
		hold_off = 1'b0;
		wait (hold_arm);
		do @(posedge clk); while (!sig_out.valid);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	function automatic logic [VAL_W-1:0] rand_val();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return VAL_MAX;
			2: return VAL_W'(1);
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic elem_item_t mk_load(input int unsigned slot, input logic [VAL_W-1:0] mul,
			input logic [VAL_W-1:0] add, input logic last);
		elem_item_t it;
		it = '{action: ACT_LOAD, slot: SLOT_W'(slot), mul: mul, add: add,
			id: VAL_W'($urandom), last: last};
		return it;
	endfunction

	function automatic elem_item_t mk_hash(input logic [VAL_W-1:0] id, input logic last);
		elem_item_t it;
		it = '{action: ACT_HASH, slot: SLOT_W'($urandom_range(0, 63)), mul: VAL_W'($urandom),
			add: VAL_W'($urandom), id: id, last: last};
		return it;
	endfunction

	function automatic elem_item_t rand_item();
		logic [VAL_W-1:0] id;
		if ($urandom_range(0, 99) < 12)
			return mk_load($urandom_range(0, 63), rand_val(), rand_val(), 1'($urandom_range(0, 1)));
		id = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom_range(0, 31)) : rand_val();
		return mk_hash(id, $urandom_range(0, 3) == 0);
	endfunction

	task automatic send_item(input elem_item_t it);
		while ($urandom_range(0, 99) < send_idle) begin
			items_in.valid <= 1'b0;
			@(posedge clk);
		end
		items_in.valid      <= 1'b1;
		items_in.action     <= it.action;
		items_in.slot_index <= it.slot;
		items_in.coef_mul   <= it.mul;
		items_in.coef_add   <= it.add;
		items_in.element_id <= it.id;
		items_in.set_last   <= it.last;
		@(posedge clk);
		while (!items_in.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// settle also covers a hash transaction that produces no words
	task automatic wait_drained(input bit settle);
		items_in.valid <= 1'b0;
		do @(posedge clk); while (open_words != 0);
		if (settle)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [VAL_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		arst_n              = 1'b0;
		wr_en               = 1'b0;
		wr_index            = REG_MODULUS;
		wr_data             = '0;
		end_of_run          = 1'b0;
		hold_arm            = 1'b0;
		items_in.valid      = 1'b0;
		items_in.action     = ACT_LOAD;
		items_in.slot_index = '0;
		items_in.coef_mul   = '0;
		items_in.coef_add   = '0;
		items_in.element_id = '0;
		items_in.set_last   = 1'b0;
		send_idle           = 25;
		recv_idle           = 53;

		phases[0] = '{31'd1000003, 7'd16, 25, 53, 40, 1'b1, 1'b0};
		phases[1] = '{31'd2, 7'd1, 25, 53, 20, 1'b0, 1'b0};
		phases[2] = '{VAL_MAX, 7'd9, 53, 25, 40, 1'b0, 1'b1};
		phases[3] = '{31'd0, 7'd127, 53, 25, 15, 1'b0, 1'b0};
		phases[4] = '{31'd1, 7'd64, 0, 0, 15, 1'b0, 1'b0};
		phases[5] = '{VAL_W'($urandom_range(2, 32'h7FFF_FFFF)), 7'd16, 0, 0, 50, 1'b0, 1'b0};
		phases[6] = '{VAL_MAX, 7'd17, 0, 0, 25, 1'b0, 1'b0};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// every built slot gets coefficients before anything is hashed
		for (int s = 0; s < NUM_SLOTS_DEF; s++) begin
			case (s)
				0: send_item(mk_load(s, VAL_MAX, VAL_MAX, 1'b0));
				1: send_item(mk_load(s, '0, '0, 1'b0));
				15: send_item(mk_load(s, rand_val(), rand_val(), 1'b1));
				default: send_item(mk_load(s, VAL_W'($urandom), VAL_W'($urandom), 1'b0));
			endcase
		end
		send_item(mk_load(NUM_SLOTS_DEF, VAL_MAX, '0, 1'b0));
		send_item(mk_load(63, VAL_W'($urandom), VAL_W'($urandom), 1'b1));
		send_item(mk_hash('0, 1'b0));
		send_item(mk_hash(VAL_MAX, 1'b0));
		send_item(mk_hash(VAL_W'($urandom), 1'b1));
		send_item(mk_hash(VAL_W'($urandom), 1'b1));
		wait_drained(1'b1);
		write_reg(REG_HASH_COUNT, VAL_W'(0));
		send_item(mk_hash(VAL_W'($urandom), 1'b1));
		wait_drained(1'b1);
		write_reg(REG_HASH_COUNT, VAL_W'(127));
		send_item(mk_hash(VAL_W'($urandom), 1'b1));
		// open set carried across the next modulus change
		send_item(mk_hash(VAL_W'($urandom), 1'b0));
		wait_drained(1'b1);

		foreach (phases[p]) begin
			write_reg(REG_MODULUS, phases[p].modulus);
			write_reg(REG_HASH_COUNT, VAL_W'(phases[p].hash_count));
			send_idle = phases[p].send_idle;
			recv_idle <= phases[p].recv_idle;
			if (phases[p].hold)
				hold_arm <= 1'b1;
			for (int i = 0; i < phases[p].n_items; i++) begin
				send_item(rand_item());
				if (phases[p].pause && i == phases[p].n_items / 2)
					wait_drained(1'b0);
			end
			wait_drained(1'b1);
		end

		end_of_run <= 1'b1;
		repeat (2) @(posedge clk);
		$display("%0d transactions sent, %0d signature words checked over %0d register settings",
			items_sent, words_checked, $size(phases) + 3);
		$display("settings took in modulus 0, 1, 2 and maximum, hash_count 0, 1 and above slots");
		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
